### rtl/mfek_pkg.sv
// ----------------------------------------------------------------------------
// mfek_pkg - shared types and constants of the max-flow block
// field widths, command codes, register indexes and controller states
// ----------------------------------------------------------------------------
package mfek_pkg;

	localparam int NODE_W = 8;
	localparam int CAP_W  = 31;
	localparam int FLOW_W = 44;

	localparam logic [CAP_W-1:0]  INF_CAP  = 31'h3f3f3f3f;
	localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

	// command codes carried on tuser
	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_SINK   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_F,
		ST_ADD_T,
		ST_SEARCH,
		ST_DEQ,
		ST_POP,
		ST_FIRST,
		ST_ARC,
		ST_AUG,
		ST_AUG_P,
		ST_AUG_A,
		ST_AUG_B,
		ST_DONE
	} state_t;

endpackage

### rtl/mfek_ram.sv
// ----------------------------------------------------------------------------
// mfek_ram - generic simple dual-port ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module mfek_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/max_flow_edmonds_karp.sv
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp - edmonds-karp maximum flow engine
// stores a directed graph as paired arcs and computes source-to-sink flow
// ----------------------------------------------------------------------------
// usage
//   input word: s_tuser holds the command (add edge, run, clear), s_tdata the
//   edge. add edge does one ram read, then writes one arc per cycle (forward,
//   then reverse), set by the single write port of the arc store; clear is
//   done as the word is accepted. run walks the graph: each bfs step dequeues
//   a node, reads its list head, then scans its arcs; each augmentation step
//   updates a path arc and its pair, all paced by the registered ram reads.
//   a run ends with one output word: total flow since the last clear and
//   the sticky overflow flag. the result sits in an output register, so
//   new commands are accepted while it waits; a second run holds in its
//   final state until the earlier word has been taken.
//   source and sink come from the cfg port; the user writes them only while idle, the block does not enforce it.
//   reset (arst_n low) empties the graph, zeroes flow and flag and sets
//   source 0, sink 1; no clearing pass is needed since head-of-list and
//   visited marks are flip-flops.
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp
	import mfek_pkg::*;
#(
	parameter int MAX_NODES = 256,
	parameter int MAX_EDGES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // from_node[7:0], to_node[15:8], capacity[46:16]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // total_flow[43:0], edge_overflow[44]
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	localparam int SLOTS = 2 * MAX_EDGES;
	localparam int AW    = $clog2(SLOTS);
	localparam int NW    = $clog2(MAX_NODES);
	localparam int ARW   = 1 + AW + NODE_W;   // next valid, next arc, target
	localparam int QW    = CAP_W + NW;        // bottleneck, node

	// rams
	logic                fr_we;
	logic [NW-1:0]       fr_waddr, fr_raddr;
	logic [AW-1:0]       fr_wdata, fr_rdata;
	logic                ar_we;
	logic [AW-1:0]       ar_waddr, ar_raddr;
	logic [ARW-1:0]      ar_wdata, ar_rdata;
	logic                cr_we;
	logic [AW-1:0]       cr_waddr, cr_raddr;
	logic [CAP_W-1:0]    cr_wdata, cr_rdata;
	logic                pr_we;
	logic [NW-1:0]       pr_waddr, pr_raddr;
	logic [AW-1:0]       pr_wdata, pr_rdata;
	logic                qr_we;
	logic [NW-1:0]       qr_waddr, qr_raddr;
	logic [QW-1:0]       qr_wdata, qr_rdata;

	// control and datapath registers
	state_t              state_q, state_nxt;
	logic [AW:0]         arc_cnt_q;
	logic [FLOW_W-1:0]   flow_q;
	logic                ovf_q;
	logic [NODE_W-1:0]   src_q, snk_q, from_q, to_q;
	logic [CAP_W-1:0]    cap_q;
	logic [MAX_NODES-1:0] first_valid_q, visited_q;
	logic [NW:0]         qh_q, qt_q;
	logic [NW-1:0]       x_q, y_q;
	logic [CAP_W-1:0]    xb_q, f_q;
	logic [AW-1:0]       arc_q;
	logic                out_valid_q;
	logic [FLOW_W-1:0]   out_flow_q;
	logic                out_ovf_q;

	// decoded helpers
	logic                in_acc;
	logic [NODE_W-1:0]   in_from, in_to;
	logic                in_range, room;
	logic [AW-1:0]       a0, a1;
	logic [NODE_W-1:0]   arc_tgt;
	logic [AW-1:0]       arc_nxt;
	logic                arc_nv;
	logic [NW-1:0]       arc_y;
	logic                take, hit_sink;
	logic [CAP_W-1:0]    nb;
	logic [FLOW_W:0]     flow_sum;
	logic                ends_ok;
	logic                ld_out;

	assign in_acc   = s_tvalid && s_tready;
	assign in_from  = s_tdata[7:0];
	assign in_to    = s_tdata[15:8];
	assign in_range = (32'(in_from) < MAX_NODES) && (32'(in_to) < MAX_NODES);
	assign room     = (32'(arc_cnt_q) + 32'd2) <= SLOTS;
	assign a0       = arc_cnt_q[AW-1:0];
	assign a1       = a0 | AW'(1);

	assign arc_tgt  = ar_rdata[NODE_W-1:0];
	assign arc_nxt  = ar_rdata[AW+NODE_W-1:NODE_W];
	assign arc_nv   = ar_rdata[ARW-1];
	assign arc_y    = NW'(arc_tgt);
	assign take     = (cr_rdata != '0) && !visited_q[arc_y];
	assign hit_sink = take && (arc_tgt == snk_q);
	assign nb       = (cr_rdata < xb_q) ? cr_rdata : xb_q;
	assign flow_sum = {1'b0, flow_q} + (FLOW_W+1)'(f_q);
	// endpoints beyond the node range give no path
	assign ends_ok  = (32'(src_q) < MAX_NODES) && (32'(snk_q) < MAX_NODES);
	assign ld_out   = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	mfek_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_first (
		.clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.raddr(fr_raddr), .rdata(fr_rdata)
	);

	mfek_ram #(.WIDTH(ARW), .DEPTH(SLOTS)) u_arc (
		.clk(clk), .we(ar_we), .waddr(ar_waddr), .wdata(ar_wdata),
		.raddr(ar_raddr), .rdata(ar_rdata)
	);

	mfek_ram #(.WIDTH(CAP_W), .DEPTH(SLOTS)) u_cap (
		.clk(clk), .we(cr_we), .waddr(cr_waddr), .wdata(cr_wdata),
		.raddr(cr_raddr), .rdata(cr_rdata)
	);

	mfek_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_pred (
		.clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
		.raddr(pr_raddr), .rdata(pr_rdata)
	);

	mfek_ram #(.WIDTH(QW), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(qr_we), .waddr(qr_waddr), .wdata(qr_wdata),
		.raddr(qr_raddr), .rdata(qr_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and ram control
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		fr_we     = 1'b0;
		fr_waddr  = NW'(from_q);
		fr_wdata  = a0;
		fr_raddr  = NW'(to_q);
		ar_we     = 1'b0;
		ar_waddr  = a0;
		ar_wdata  = {first_valid_q[NW'(from_q)], fr_rdata, to_q};
		ar_raddr  = arc_q;
		cr_we     = 1'b0;
		cr_waddr  = a0;
		cr_wdata  = cap_q;
		cr_raddr  = arc_q;
		pr_we     = 1'b0;
		pr_waddr  = arc_y;
		pr_wdata  = arc_q;
		pr_raddr  = y_q;
		qr_we     = 1'b0;
		qr_waddr  = qt_q[NW-1:0];
		qr_wdata  = {nb, arc_y};
		qr_raddr  = qh_q[NW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				fr_raddr = NW'(in_from);
				if (in_acc) begin
					case (s_tuser)
						MODE_ADD: if (in_range && room) state_nxt = ST_ADD_F;
						MODE_RUN: state_nxt = ST_SEARCH;
						default:  state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_ADD_F: begin
				// forward arc onto the head of the tail's list
				ar_we     = 1'b1;
				cr_we     = 1'b1;
				fr_we     = 1'b1;
				state_nxt = ST_ADD_T;
			end
			ST_ADD_T: begin
				// reverse arc; a self loop sees the head just written
				ar_we    = 1'b1;
				ar_waddr = a1;
				ar_wdata = {first_valid_q[NW'(to_q)],
					(to_q == from_q) ? a0 : fr_rdata, from_q};
				cr_we    = 1'b1;
				cr_waddr = a1;
				cr_wdata = '0;
				fr_we    = 1'b1;
				fr_waddr = NW'(to_q);
				fr_wdata = a1;
				state_nxt = ST_IDLE;
			end
			ST_SEARCH: begin
				if (!ends_ok) begin
					state_nxt = ST_DONE;
				end else begin
					qr_we     = 1'b1;
					qr_waddr  = '0;
					qr_wdata  = {INF_CAP, NW'(src_q)};
					state_nxt = ST_DEQ;
				end
			end
			ST_DEQ: begin
				state_nxt = (qh_q == qt_q) ? ST_DONE : ST_POP;
			end
			ST_POP: begin
				fr_raddr  = qr_rdata[NW-1:0];
				state_nxt = ST_FIRST;
			end
			ST_FIRST: begin
				ar_raddr = fr_rdata;
				cr_raddr = fr_rdata;
				state_nxt = first_valid_q[x_q] ? ST_ARC : ST_DEQ;
			end
			ST_ARC: begin
				ar_raddr = arc_nxt;
				cr_raddr = arc_nxt;
				if (take) begin
					pr_we = 1'b1;
					qr_we = 1'b1;
				end
				if (hit_sink) begin
					state_nxt = ST_AUG;
				end else if (!arc_nv) begin
					state_nxt = ST_DEQ;
				end
			end
			ST_AUG: begin
				state_nxt = (y_q == NW'(src_q)) ? ST_SEARCH : ST_AUG_P;
			end
			ST_AUG_P: begin
				cr_raddr  = pr_rdata;
				ar_raddr  = pr_rdata ^ AW'(1);
				state_nxt = ST_AUG_A;
			end
			ST_AUG_A: begin
				cr_we     = 1'b1;
				cr_waddr  = arc_q;
				cr_wdata  = cr_rdata - f_q;
				cr_raddr  = arc_q ^ AW'(1);
				state_nxt = ST_AUG_B;
			end
			ST_AUG_B: begin
				cr_we     = 1'b1;
				cr_waddr  = arc_q ^ AW'(1);
				cr_wdata  = cr_rdata + f_q;
				state_nxt = ST_AUG;
			end
			ST_DONE: begin
				if (ld_out) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// graph bookkeeping, search and augment registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_cnt_q     <= '0;
			flow_q        <= '0;
			ovf_q         <= 1'b0;
			first_valid_q <= '0;
			visited_q     <= '0;
			qh_q          <= '0;
			qt_q          <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == MODE_CLEAR) begin
						arc_cnt_q     <= '0;
						flow_q        <= '0;
						ovf_q         <= 1'b0;
						first_valid_q <= '0;
					end else if (in_acc && s_tuser == MODE_ADD && in_range && !room) begin
						ovf_q <= 1'b1;
					end
				end
				ST_ADD_F: first_valid_q[NW'(from_q)] <= 1'b1;
				ST_ADD_T: begin
					first_valid_q[NW'(to_q)] <= 1'b1;
					arc_cnt_q <= arc_cnt_q + (AW+1)'(2);
				end
				ST_SEARCH: begin
					if (ends_ok) begin
						// only the source is marked at the start of a search
						visited_q <= {{(MAX_NODES-1){1'b0}}, 1'b1} << NW'(src_q);
						qh_q <= '0;
						qt_q <= (NW+1)'(1);
					end
				end
				ST_DEQ: if (qh_q != qt_q) qh_q <= qh_q + (NW+1)'(1);
				ST_ARC: begin
					if (take) begin
						visited_q[arc_y] <= 1'b1;
						qt_q <= qt_q + (NW+1)'(1);
					end
				end
				ST_AUG: begin
					if (y_q == NW'(src_q)) begin
						flow_q <= flow_sum[FLOW_W] ? FLOW_MAX : flow_sum[FLOW_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			from_q <= in_from;
			to_q   <= in_to;
			cap_q  <= s_tdata[46:16];
		end
		case (state_q)
			ST_POP: begin
				x_q  <= qr_rdata[NW-1:0];
				xb_q <= qr_rdata[QW-1:NW];
			end
			ST_FIRST: arc_q <= fr_rdata;
			ST_ARC: begin
				arc_q <= arc_nxt;
				if (hit_sink) begin
					f_q <= nb;
					y_q <= NW'(snk_q);
				end
			end
			ST_AUG_P: arc_q <= pr_rdata;
			ST_AUG_A: y_q <= NW'(arc_tgt);
			default: ;
		endcase
		if (ld_out) begin
			out_flow_q <= flow_q;
			out_ovf_q  <= ovf_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= 8'd0;
			snk_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SOURCE: src_q <= cfg_wdata;
				REG_SINK:   snk_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_ovf_q, out_flow_q};

	// queue head never passes the tail
	assert property (@(posedge clk) disable iff (!arst_n) qh_q <= qt_q)
		else $error("bfs queue head beyond tail");

	// arc store never holds more arcs than slots
	assert property (@(posedge clk) disable iff (!arst_n) 32'(arc_cnt_q) <= SLOTS)
		else $error("arc count beyond store size");

	// a pending word is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output word lost while stalled");

	// augmentation only follows a found path with non-zero bottleneck
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AUG_A) |-> (f_q != '0))
		else $error("augment with zero bottleneck");

endmodule
